// File: hw/rtl/asb_pkg.sv
`timescale 1ns / 1ps

package asb_pkg;

   // Item function codes.
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_TUNE  = 2'd1;
   localparam logic [1:0] FUNC_AMP   = 2'd2;
   localparam logic [1:0] FUNC_PHASE = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [7:0] CSR_ENV_LEN    = 8'd0;
   localparam logic [7:0] CSR_FREQ_LIMIT = 8'd1;

   localparam logic [15:0] ENV_LEN_RESET    = 16'd480;
   localparam logic [23:0] FREQ_LIMIT_RESET = 24'd352800;

   // 0.001 in Q8.24.
   localparam logic signed [31:0] AMP_QUIET = 32'sd16777;
   // 1.0 in Q2.30.
   localparam logic signed [31:0] X_RESET   = 32'sh40000000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } osc_type;

   typedef struct packed {
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic [23:0]        freq;
   } tune_type;

   typedef struct packed {
      logic signed [31:0] now;
      logic signed [31:0] target;
      logic signed [31:0] step;
      logic [15:0]        steps;
   } amp_type;

   typedef struct packed {
      logic        start;
      logic        neg;
      logic [31:0] mag;
      logic [15:0] divisor;
   } div_req_type;

   // Arithmetic shift right with round half up.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] p,
                                                      input int unsigned s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      return (p + half) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/additive_sine_bank_top.sv
`timescale 1ns / 1ps
// A tick walks every partial through S_RD to S_ACC, then raises its sample from S_OUT;
// one shared 32x32 multiplier serves four products per partial.
// The next item can transfer in the same cycle that the sample appears. Set tuning writes from idle;
// set amplitude passes S_ARD and S_AMP, and waits in S_DIV for the serial divider; load phase
// writes one memory row per cycle over all partials. One item at a time.
// Synchronous active-high reset, then a clearing pass over all partials with no item taken.
module additive_sine_bank_top #(
   parameter int NUM_PARTIALS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_partial_index,
   input  logic signed [31:0] req_coef_k1,
   input  logic signed [31:0] req_coef_k2,
   input  logic [23:0]        req_partial_frequency,
   input  logic signed [31:0] req_amplitude_value,
   input  logic               req_use_envelope,
   input  logic signed [31:0] req_phase_cos,
   input  logic signed [31:0] req_phase_sin,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [23:0]        csr_data
);

   // Index width of the partial memories.
   localparam int IW    = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1;
   // Each rounded term is 34 bits; the sum grows by the partial count.
   localparam int ACC_W = 35 + $clog2(NUM_PARTIALS);

   // Sequencer states. One partial of a tick walks S_RD through S_ACC.
   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_M1   = 4'd3;
   localparam logic [3:0] S_T    = 4'd4;
   localparam logic [3:0] S_M2   = 4'd5;
   localparam logic [3:0] S_Y    = 4'd6;
   localparam logic [3:0] S_M3   = 4'd7;
   localparam logic [3:0] S_X    = 4'd8;
   localparam logic [3:0] S_M4   = 4'd9;
   localparam logic [3:0] S_ACC  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;
   localparam logic [3:0] S_LOAD = 4'd12;
   localparam logic [3:0] S_ARD  = 4'd13;
   localparam logic [3:0] S_AMP  = 4'd14;
   localparam logic [3:0] S_DIV  = 4'd15;

   logic [3:0]                state_ff, state_in;
   logic [IW-1:0]             cnt_ff, cnt_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [63:0]        prod_ff, prod_in;
   logic signed [31:0]        t_ff, t_in;
   logic signed [31:0]        x_ff, x_in;
   logic signed [31:0]        y_ff, y_in;
   logic signed [31:0]        amp_ff, amp_in;
   logic [15:0]               steps_ff, steps_in;
   logic                      on_ff, on_in;
   logic signed [31:0]        val_ff, val_in;
   logic                      env_ff, env_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]        rsp_sample_ff, rsp_sample_in;
   logic [15:0]               env_len_ff;
   logic [23:0]               freq_limit_ff;

   // Per-partial state, split by which items write it.
   asb_pkg::osc_type  osc_mem  [NUM_PARTIALS];
   asb_pkg::tune_type tune_mem [NUM_PARTIALS];
   asb_pkg::amp_type  amp_mem  [NUM_PARTIALS];
   asb_pkg::osc_type  osc_rd_ff;
   asb_pkg::tune_type tune_rd_ff;
   asb_pkg::amp_type  amp_rd_ff;

   logic              osc_we, tune_we, amp_we;
   logic [IW-1:0]     tune_wa;
   asb_pkg::osc_type  osc_wd;
   asb_pkg::tune_type tune_wd;
   asb_pkg::amp_type  amp_wd;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_mul;

   logic                 last;
   logic                 in_range;
   logic [IW-1:0]        req_addr;
   logic signed [32:0]   diff;
   logic                 amp_loud;

   asb_pkg::div_req_type div_req;
   logic                 div_done;
   logic signed [31:0]   div_quot;

   assign last     = cnt_ff == IW'(NUM_PARTIALS - 1);
   assign in_range = 32'(req_partial_index) < NUM_PARTIALS;
   assign req_addr = IW'(req_partial_index);
   assign diff     = 33'(val_ff) - 33'(amp_rd_ff.now);
   assign amp_loud = (amp_rd_ff.now > asb_pkg::AMP_QUIET) ||
                     (amp_rd_ff.now < -asb_pkg::AMP_QUIET);

   // The shared multiplier. Its product is registered in prod_ff in S_M1 to S_M4.
   assign prod_mul = mul_a * mul_b;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      t_in          = t_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      amp_in        = amp_ff;
      steps_in      = steps_ff;
      on_in         = on_ff;
      val_in        = val_ff;
      env_in        = env_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      mul_a         = tune_rd_ff.k1;
      mul_b         = osc_rd_ff.y;
      osc_we        = 1'b0;
      osc_wd        = '{x: x_ff, y: y_ff};
      tune_we       = 1'b0;
      tune_wa       = req_addr;
      tune_wd       = '{k1: req_coef_k1, k2: req_coef_k2, freq: req_partial_frequency};
      amp_we        = 1'b0;
      amp_wd        = amp_rd_ff;
      div_req       = '0;

      case (state_ff)
         S_CLR: begin
            osc_we  = 1'b1;
            osc_wd  = '{x: asb_pkg::X_RESET, y: '0};
            tune_we = 1'b1;
            tune_wa = cnt_ff;
            tune_wd = '0;
            amp_we  = 1'b1;
            amp_wd  = '0;
            if (last) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  asb_pkg::FUNC_TICK: begin
                     cnt_in   = '0;
                     acc_in   = '0;
                     state_in = S_RD;
                  end
                  asb_pkg::FUNC_TUNE: begin
                     tune_we = in_range;
                  end
                  asb_pkg::FUNC_AMP: begin
                     if (in_range) begin
                        cnt_in   = req_addr;
                        val_in   = req_amplitude_value;
                        env_in   = req_use_envelope;
                        state_in = S_ARD;
                     end
                  end
                  asb_pkg::FUNC_PHASE: begin
                     x_in     = req_phase_cos;
                     y_in     = req_phase_sin;
                     cnt_in   = '0;
                     state_in = S_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         S_RD: state_in = S_M1;
         S_M1: begin
            // t needs k1*y; the ramp of this partial is settled meanwhile.
            prod_in = prod_mul;
            on_in   = (tune_rd_ff.freq < freq_limit_ff) &&
                      (amp_loud || (amp_rd_ff.steps != 16'd0));
            amp_in   = amp_rd_ff.now;
            steps_in = amp_rd_ff.steps;
            if (on_in && (amp_rd_ff.steps != 16'd0)) begin
               amp_in   = (amp_rd_ff.steps == 16'd1) ? amp_rd_ff.target :
                          asb_pkg::sat32(64'(amp_rd_ff.now) + 64'(amp_rd_ff.step));
               steps_in = amp_rd_ff.steps - 16'd1;
            end
            state_in = S_T;
         end
         S_T: begin
            t_in = asb_pkg::sat32(64'(osc_rd_ff.x) - asb_pkg::round_shift(prod_ff, 24));
            state_in = S_M2;
         end
         S_M2: begin
            mul_a    = tune_rd_ff.k2;
            mul_b    = t_ff;
            prod_in  = prod_mul;
            state_in = S_Y;
         end
         S_Y: begin
            y_in = asb_pkg::sat32(64'(osc_rd_ff.y) + asb_pkg::round_shift(prod_ff, 30));
            state_in = S_M3;
         end
         S_M3: begin
            mul_a    = tune_rd_ff.k1;
            mul_b    = y_ff;
            prod_in  = prod_mul;
            state_in = S_X;
         end
         S_X: begin
            x_in = asb_pkg::sat32(64'(t_ff) - asb_pkg::round_shift(prod_ff, 24));
            state_in = S_M4;
         end
         S_M4: begin
            mul_a    = y_ff;
            mul_b    = amp_ff;
            prod_in  = prod_mul;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (on_ff) begin
               acc_in = acc_ff + ACC_W'(asb_pkg::round_shift(prod_ff, 30));
            end
            osc_we = 1'b1;
            amp_we = 1'b1;
            amp_wd = '{now: amp_ff, target: amp_rd_ff.target, step: amp_rd_ff.step,
                       steps: steps_ff};
            if (last) begin
               state_in = S_OUT;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_OUT: begin
            // Wait here only while an earlier sample is still not taken.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = asb_pkg::sat32(64'(acc_ff));
               state_in      = S_IDLE;
            end
         end
         S_LOAD: begin
            osc_we = 1'b1;
            if (last) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ARD: state_in = S_AMP;
         S_AMP: begin
            div_req.neg = diff[32];
            div_req.mag = diff[32] ? 32'(-diff) : diff[31:0];
            if (env_ff && (env_len_ff != 16'd0)) begin
               div_req.start   = 1'b1;
               div_req.divisor = env_len_ff;
               steps_in        = env_len_ff;
               state_in        = S_DIV;
            end else if (env_ff) begin
               amp_we       = 1'b1;
               amp_wd.now   = val_ff;
               amp_wd.steps = '0;
               state_in     = S_IDLE;
            end else if (amp_rd_ff.steps != 16'd0) begin
               div_req.start   = 1'b1;
               div_req.divisor = amp_rd_ff.steps;
               steps_in        = amp_rd_ff.steps;
               state_in        = S_DIV;
            end else begin
               amp_we     = 1'b1;
               amp_wd.now = val_ff;
               state_in   = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               amp_we        = 1'b1;
               amp_wd.target = val_ff;
               amp_wd.step   = div_quot;
               amp_wd.steps  = steps_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      t_ff          <= t_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      amp_ff        <= amp_in;
      steps_ff      <= steps_in;
      on_ff         <= on_in;
      val_ff        <= val_in;
      env_ff        <= env_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // Configuration registers. A write to an unknown index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         env_len_ff    <= asb_pkg::ENV_LEN_RESET;
         freq_limit_ff <= asb_pkg::FREQ_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            asb_pkg::CSR_ENV_LEN:    env_len_ff    <= csr_data[15:0];
            asb_pkg::CSR_FREQ_LIMIT: freq_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Partial memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (osc_we) begin
         osc_mem[cnt_ff] <= osc_wd;
      end
      if (tune_we) begin
         tune_mem[tune_wa] <= tune_wd;
      end
      if (amp_we) begin
         amp_mem[cnt_ff] <= amp_wd;
      end
      osc_rd_ff  <= osc_mem[cnt_ff];
      tune_rd_ff <= tune_mem[cnt_ff];
      amp_rd_ff  <= amp_mem[cnt_ff];
   end

   asb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_ready  = state_ff == S_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("block ready right after reset");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider result outside its wait state");

   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_OUT)
      else $error("sample raised outside the end of a tick");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= IW'(NUM_PARTIALS - 1))
      else $error("partial counter out of range");

endmodule

// File: hw/rtl/asb_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient is truncated
// toward zero, signed by neg and saturated to 32 bits.
module asb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  asb_pkg::div_req_type req,
   output logic                 done,
   output logic signed [31:0]   quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [16:0] rem_sh;
   logic [16:0] rem_sub;
   logic        ge;

   assign rem_sh  = {rem_ff, q_ff[31]};
   assign ge      = rem_sh >= {1'b0, div_ff};
   assign rem_sub = rem_sh - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         q_in    = req.mag;
         rem_in  = '0;
         div_in  = req.divisor;
         neg_in  = req.neg;
      end else if (busy_ff) begin
         q_in   = {q_ff[30:0], ge};
         rem_in = ge ? rem_sub[15:0] : rem_sh[15:0];
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (neg_ff) begin
         quot = (q_ff > 32'h80000000) ? 32'sh80000000 : $signed(-q_ff);
      end else begin
         quot = q_ff[31] ? 32'sh7fffffff : $signed(q_ff);
      end
   end

   assign done = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start)
      else $error("divider started while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_done_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) && !$past(req.start) |-> done_ff)
      else $error("divider finished without done");

endmodule
